[src/yaw_rate_lowpass_packer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the yaw rate low-pass packer
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef YAW_RATE_LOWPASS_PACKER_UNIT_MACROS_SVH
`define YAW_RATE_LOWPASS_PACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define YRLP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yrlp check failed");
// next-cycle implication
`define YRLP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yrlp check failed");
`else
`define YRLP_ASSERT_IMP(name, clk, rst, ante, cons)
`define YRLP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

[src/yrlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrlp_pkg
// Shared widths and constants of the yaw rate low-pass packer.
// ----------------------------------------------------------------------------
package yrlp_pkg;

   localparam int YAW_W    = 16;   // input yaw sample
   localparam int DIFF_W   = 17;   // wrapped yaw difference
   localparam int STATE_W  = 32;   // filter stage state
   localparam int DELTA_W  = 33;   // x - y
   localparam int GAIN_W   = 16;   // alpha register
   localparam int PROD_W   = 50;   // delta * alpha
   localparam int GAIN_FRAC = 15;  // alpha is unsigned Q1.15
   localparam int MAG_W    = 16;   // output magnitude
   localparam int BYTE_W   = 8;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd9830;
   localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd32768;

   localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd18000;
   localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd36000;

endpackage

[src/yrlp_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrlp_step_unit
// Shared first-order stage update: y + round(alpha * (x - y) / 2^15); the
// product is registered, then rounded, added and saturated combinationally.
// ----------------------------------------------------------------------------
module yrlp_step_unit (
   input  logic                                 clock,
   input  logic                                 prod_en,
   input  logic signed [yrlp_pkg::STATE_W-1:0]  target_i,
   input  logic signed [yrlp_pkg::STATE_W-1:0]  y_i,
   input  logic        [yrlp_pkg::GAIN_W-1:0]   alpha_i,
   output logic signed [yrlp_pkg::STATE_W-1:0]  y_next
);

   localparam int RND_W = yrlp_pkg::PROD_W + 1;
   localparam int SH_W  = RND_W - yrlp_pkg::GAIN_FRAC;
   localparam int SUM_W = SH_W + 1;

   localparam logic signed [RND_W-1:0] ROUND_HALF =
      RND_W'(52'sd1 <<< (yrlp_pkg::GAIN_FRAC - 1));
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(33'sh1_8000_0000);

   logic signed [yrlp_pkg::DELTA_W-1:0] delta;
   logic signed [yrlp_pkg::GAIN_W:0]    alpha_s;
   logic signed [yrlp_pkg::PROD_W-1:0]  prod_in;
   logic signed [yrlp_pkg::PROD_W-1:0]  prod_ff;
   logic signed [RND_W-1:0]             rounded;
   logic signed [SH_W-1:0]              shifted;
   logic signed [SUM_W-1:0]             sum;

   // multiply cycle
   always_comb begin
      delta   = {target_i[yrlp_pkg::STATE_W-1], target_i} - {y_i[yrlp_pkg::STATE_W-1], y_i};
      alpha_s = {1'b0, alpha_i};
      prod_in = yrlp_pkg::PROD_W'(delta * alpha_s);
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff <= prod_in;
      end
   end

   // round to nearest (ties up), floor shift, accumulate, saturate
   always_comb begin
      rounded = {prod_ff[yrlp_pkg::PROD_W-1], prod_ff} + ROUND_HALF;
      shifted = rounded[RND_W-1:yrlp_pkg::GAIN_FRAC];
      sum     = {shifted[SH_W-1], shifted} + SUM_W'(y_i);
      if (sum > SAT_HI) begin
         y_next = SAT_HI[yrlp_pkg::STATE_W-1:0];
      end else if (sum < SAT_LO) begin
         y_next = SAT_LO[yrlp_pkg::STATE_W-1:0];
      end else begin
         y_next = sum[yrlp_pkg::STATE_W-1:0];
      end
   end

endmodule

[src/yrlp_pack_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrlp_pack_out
// Sign/magnitude packing of the second stage and the result beat register.
// ----------------------------------------------------------------------------
module yrlp_pack_out #(
   parameter int FRAC_BITS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_en,
   input  logic signed [yrlp_pkg::STATE_W-1:0]  stage_i,
   output logic                                 load_ready,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [2*yrlp_pkg::BYTE_W-1:0]        rsp_tdata,  // [7:0] magnitude_high, [15:8] magnitude_low
   output logic                                 rsp_tuser   // [0] negative_flag
);

   logic [yrlp_pkg::STATE_W:0]   ext_val;
   logic [yrlp_pkg::STATE_W:0]   abs_val;
   logic [yrlp_pkg::STATE_W-1:0] shifted;
   logic [yrlp_pkg::MAG_W-1:0]   mag;
   logic                         neg;

   logic                         valid_ff;
   logic                         valid_in;
   logic [2*yrlp_pkg::BYTE_W-1:0] data_ff;
   logic                         user_ff;

   // magnitude truncated toward zero, saturated to 16 bits
   always_comb begin
      ext_val = {stage_i[yrlp_pkg::STATE_W-1], stage_i};
      abs_val = stage_i[yrlp_pkg::STATE_W-1] ? (~ext_val + 1'b1) : ext_val;
      shifted = abs_val[yrlp_pkg::STATE_W-1:0] >> FRAC_BITS;
      mag     = (|shifted[yrlp_pkg::STATE_W-1:yrlp_pkg::MAG_W]) ? '1
                                                                : shifted[yrlp_pkg::MAG_W-1:0];
      neg     = stage_i[yrlp_pkg::STATE_W-1] && (mag != '0);
   end

   // output beat register
   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load_en) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         data_ff <= {mag[yrlp_pkg::BYTE_W-1:0], mag[yrlp_pkg::MAG_W-1:yrlp_pkg::BYTE_W]};
         user_ff <= neg;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

[src/yaw_rate_lowpass_packer_unit.sv]
`timescale 1ns / 1ps
// Yaw rate low-pass packer. Each req beat carries one yaw sample; the first
// sample after reset only primes the previous-yaw register and gives no rsp
// beat. Every later sample runs from acceptance until the block is ready
// again through wrap, load x, then multiply and add for stage one and for
// stage two on the one shared 33x17 multiplier, then load the result beat,
// which waits in S_PACK while the result register cannot take it.
// req_tready is high only while the sequencer is idle. filter_gain is
// written through csr_wr_en/csr_wr_data and should only change while idle.
// ----------------------------------------------------------------------------
// yaw_rate_lowpass_packer_unit
// Yaw difference, +/-180 degree wrap, two cascaded IIR low-pass stages and
// sign/magnitude packing of the filtered yaw change.
// ----------------------------------------------------------------------------
`include "yaw_rate_lowpass_packer_unit_macros.svh"

module yaw_rate_lowpass_packer_unit #(
   parameter int FRAC_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [yrlp_pkg::YAW_W-1:0]          req_tdata,   // [15:0] yaw_centideg
   // result output
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2*yrlp_pkg::BYTE_W-1:0]       rsp_tdata,   // [7:0] magnitude_high, [15:8] magnitude_low
   output logic                                rsp_tuser,   // [0] negative_flag
   // filter_gain register
   input  logic                                csr_wr_en,
   input  logic [yrlp_pkg::GAIN_W-1:0]         csr_wr_data
);

   localparam int XW = yrlp_pkg::DIFF_W + FRAC_BITS;
   localparam int XE = (XW > yrlp_pkg::DELTA_W) ? XW : yrlp_pkg::DELTA_W;
   localparam logic signed [XE-1:0] X_HI = XE'(33'sh0_7FFF_FFFF);
   localparam logic signed [XE-1:0] X_LO = XE'(33'sh1_8000_0000);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PRIME = 7'b0000010,
      S_MUL1  = 7'b0000100,
      S_ADD1  = 7'b0001000,
      S_MUL2  = 7'b0010000,
      S_ADD2  = 7'b0100000,
      S_PACK  = 7'b1000000
   } state_type;

   state_type                               state_ff, state_in;
   logic [yrlp_pkg::GAIN_W-1:0]             gain_ff, gain_in;
   logic                                    first_seen_ff, first_seen_in;
   logic                                    primed_ff, primed_in;
   logic [yrlp_pkg::YAW_W-1:0]              prev_ff, prev_in;
   logic signed [yrlp_pkg::DIFF_W-1:0]      diff_ff, diff_in;
   logic signed [yrlp_pkg::STATE_W-1:0]     x_ff, x_in;
   logic signed [yrlp_pkg::STATE_W-1:0]     s1_ff, s1_in;
   logic signed [yrlp_pkg::STATE_W-1:0]     s2_ff, s2_in;

   logic                                    req_accept;
   logic signed [yrlp_pkg::DIFF_W-1:0]      diff_raw;
   logic signed [yrlp_pkg::DIFF_W-1:0]      diff_hi;
   logic signed [yrlp_pkg::DIFF_W-1:0]      diff_wrap;
   logic signed [XW-1:0]                    x_wide;
   logic signed [XE-1:0]                    x_ext;
   logic signed [yrlp_pkg::STATE_W-1:0]     x_sat;
   logic [yrlp_pkg::GAIN_W-1:0]             alpha;
   logic                                    second_stage;
   logic                                    prod_en;
   logic signed [yrlp_pkg::STATE_W-1:0]     step_target;
   logic signed [yrlp_pkg::STATE_W-1:0]     step_y;
   logic signed [yrlp_pkg::STATE_W-1:0]     step_next;
   logic                                    pack_ready;
   logic                                    rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // yaw difference, wrapped once in each direction
   always_comb begin
      diff_raw  = {req_tdata[yrlp_pkg::YAW_W-1], req_tdata}
                - {prev_ff[yrlp_pkg::YAW_W-1], prev_ff};
      diff_hi   = (diff_raw > yrlp_pkg::HALF_TURN) ? diff_raw - yrlp_pkg::FULL_TURN
                                                   : diff_raw;
      diff_wrap = (diff_hi < -yrlp_pkg::HALF_TURN) ? diff_hi + yrlp_pkg::FULL_TURN
                                                   : diff_hi;
   end

   // stage input x = diff * 2^FRAC_BITS, saturated to 32 bits
   always_comb begin
      x_wide = $signed({diff_ff, {FRAC_BITS{1'b0}}});
      x_ext  = XE'(x_wide);
      if (x_ext > X_HI) begin
         x_sat = X_HI[yrlp_pkg::STATE_W-1:0];
      end else if (x_ext < X_LO) begin
         x_sat = X_LO[yrlp_pkg::STATE_W-1:0];
      end else begin
         x_sat = x_ext[yrlp_pkg::STATE_W-1:0];
      end
   end

   // gain above one counts as one
   assign alpha = (gain_ff > yrlp_pkg::GAIN_ONE) ? yrlp_pkg::GAIN_ONE : gain_ff;

   // shared step unit operands
   assign second_stage = (state_ff == S_MUL2) || (state_ff == S_ADD2);
   assign prod_en      = (state_ff == S_MUL1) || (state_ff == S_MUL2);
   assign step_target  = second_stage ? s1_ff : x_ff;
   assign step_y       = second_stage ? s2_ff : s1_ff;

   yrlp_step_unit u_step (
      .clock    (clock),
      .prod_en  (prod_en),
      .target_i (step_target),
      .y_i      (step_y),
      .alpha_i  (alpha),
      .y_next   (step_next)
   );

   assign rsp_load = (state_ff == S_PACK) && pack_ready;

   yrlp_pack_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pack (
      .clock      (clock),
      .reset      (reset),
      .load_en    (rsp_load),
      .stage_i    (s2_ff),
      .load_ready (pack_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // sequencer and state updates
   always_comb begin
      state_in      = state_ff;
      gain_in       = csr_wr_en ? csr_wr_data : gain_ff;
      first_seen_in = first_seen_ff;
      primed_in     = primed_ff;
      prev_in       = prev_ff;
      diff_in       = diff_ff;
      x_in          = x_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               prev_in = req_tdata;
               if (first_seen_ff) begin
                  diff_in  = diff_wrap;
                  state_in = S_PRIME;
               end else begin
                  first_seen_in = 1'b1;
               end
            end
         end
         S_PRIME: begin
            x_in = x_sat;
            if (!primed_ff) begin
               s1_in     = x_sat;
               s2_in     = x_sat;
               primed_in = 1'b1;
            end
            state_in = S_MUL1;
         end
         S_MUL1: begin
            state_in = S_ADD1;
         end
         S_ADD1: begin
            s1_in    = step_next;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_ADD2;
         end
         S_ADD2: begin
            s2_in    = step_next;
            state_in = S_PACK;
         end
         S_PACK: begin
            if (pack_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gain_ff       <= yrlp_pkg::GAIN_RESET;
         first_seen_ff <= 1'b0;
         primed_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_ff       <= gain_in;
         first_seen_ff <= first_seen_in;
         primed_ff     <= primed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      diff_ff <= diff_in;
      x_ff    <= x_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
   end

   // checks
   `YRLP_ASSERT_NXT(a_first_sample_no_work, clock, reset,
      req_accept && !first_seen_ff, (state_ff == S_IDLE) && first_seen_ff)
   `YRLP_ASSERT_NXT(a_sample_starts_work, clock, reset,
      req_accept && first_seen_ff, state_ff == S_PRIME)
   `YRLP_ASSERT_IMP(a_result_only_when_primed, clock, reset,
      rsp_load, primed_ff && first_seen_ff)
   `YRLP_ASSERT_NXT(a_primed_sticks, clock, reset,
      primed_ff, primed_ff)
   `YRLP_ASSERT_NXT(a_stage_two_then_pack, clock, reset,
      state_ff == S_ADD2, state_ff == S_PACK)

endmodule

[tb/sv/yaw_rate_lowpass_packer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_rate_lowpass_packer_unit_tb
// Drives yaw samples into the packer and checks every result beat against a
// local model of the wrap, the two low-pass stages and the sign/magnitude
// packing, or against typed values for some directed rows. A short table of
// directed samples comes first. Random phases follow, each with its own
// filter gain. Both stream sides idle at random except in the last phase.
// ----------------------------------------------------------------------------
module yaw_rate_lowpass_packer_unit_tb;

   localparam int FRAC_BITS      = 15;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam int DIRECTED_ROWS  = 23;
   localparam longint STATE_MAX  = 64'sd2147483647;
   localparam longint STATE_MIN  = -64'sd2147483648;
   localparam longint MAG_MAX    = 64'sd65535;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} row_check_type;

   typedef struct packed {
      logic                        neg;
      logic [yrlp_pkg::BYTE_W-1:0] mag_high;
      logic [yrlp_pkg::BYTE_W-1:0] mag_low;
   } yaw_beat_type;

   typedef struct {
      bit                          write_gain;
      logic [yrlp_pkg::GAIN_W-1:0] gain;
      logic [yrlp_pkg::YAW_W-1:0]  yaw;
      row_check_type               check;
      logic                        neg;
      logic [yrlp_pkg::MAG_W-1:0]  mag;
   } directed_row_type;

   // gain write flag, gain, yaw, how the row is checked, typed sign and magnitude
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{1'b0, 16'd0,      16'd0,       CHECK_NONE,  1'b0, 16'd0},     // primes only
      '{1'b0, 16'd0,      16'd18000,   CHECK_TYPED, 1'b0, 16'd18000}, // stages loaded
      '{1'b0, 16'd0,      16'(-18000), CHECK_MODEL, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'd17000,   CHECK_MODEL, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'h8000,    CHECK_MODEL, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'h7FFF,    CHECK_MODEL, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'd1,       CHECK_MODEL, 1'b0, 16'd0},
      // unity gain: output is the wrapped difference itself
      '{1'b1, yrlp_pkg::GAIN_ONE, 16'd18001, CHECK_TYPED, 1'b0, 16'd18000},
      '{1'b0, 16'd0,      16'd1,       CHECK_TYPED, 1'b1, 16'd18000},
      '{1'b0, 16'd0,      16'd18002,   CHECK_TYPED, 1'b1, 16'd17999},
      '{1'b0, 16'd0,      16'd1,       CHECK_TYPED, 1'b0, 16'd17999},
      '{1'b0, 16'd0,      16'h7FFF,    CHECK_TYPED, 1'b1, 16'd3234},
      '{1'b0, 16'd0,      16'h8000,    CHECK_TYPED, 1'b1, 16'd29535},
      '{1'b0, 16'd0,      16'h7FFF,    CHECK_TYPED, 1'b0, 16'd29535},
      '{1'b0, 16'd0,      16'h7FFF,    CHECK_TYPED, 1'b0, 16'd0},
      // gain above one clips to one
      '{1'b1, 16'hFFFF,   16'd32667,   CHECK_TYPED, 1'b1, 16'd100},
      '{1'b0, 16'd0,      16'd32667,   CHECK_TYPED, 1'b0, 16'd0},
      // zero gain freezes both stages
      '{1'b1, 16'd0,      16'd0,       CHECK_TYPED, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'd10000,   CHECK_TYPED, 1'b0, 16'd0},
      // small negative output truncates to zero, flag stays clear
      '{1'b1, yrlp_pkg::GAIN_RESET, 16'd9999, CHECK_TYPED, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'd9999,    CHECK_MODEL, 1'b0, 16'd0},
      '{1'b1, 16'd1,      16'(-10000), CHECK_MODEL, 1'b0, 16'd0},
      '{1'b0, 16'd0,      16'd20000,   CHECK_MODEL, 1'b0, 16'd0}
   };

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [yrlp_pkg::YAW_W-1:0]        req_tdata   = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [2*yrlp_pkg::BYTE_W-1:0]     rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_wr_en   = 1'b0;
   logic [yrlp_pkg::GAIN_W-1:0]       csr_wr_data = '0;

   // local copy of the block state
   logic [yrlp_pkg::GAIN_W-1:0]       gain_shadow = yrlp_pkg::GAIN_RESET;
   bit                                seen_first;
   bit                                stages_loaded;
   logic [yrlp_pkg::YAW_W-1:0]        held_yaw;
   longint                            stage_a;
   longint                            stage_b;

   yaw_beat_type            expected_beats [$];
   int                      error_count  = 0;
   bit                      send_gaps    = 1'b1;
   bit                      stall_enable = 1'b1;
   int                      stall_left   = 0;
   int                      idle_cycles  = 0;

   yaw_rate_lowpass_packer_unit #(
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [15:0] yaw_centideg
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [7:0] magnitude_high, [15:8] magnitude_low
      .rsp_tuser  (rsp_tuser),     // [0] negative_flag
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint clamp_state(input longint v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v;
   endfunction

   // y + round(alpha * (x - y) / 2^15), ties toward +inf
   function automatic longint lowpass_step(input longint y, input longint target,
                                           input longint alpha);
      longint p;
      p = alpha * (target - y) + (64'sd1 <<< (yrlp_pkg::GAIN_FRAC - 1));
      return clamp_state(y + (p >>> yrlp_pkg::GAIN_FRAC));
   endfunction

   // advance the local state by one sample, return the beat it causes
   function automatic void predict_yaw_rate(input logic [yrlp_pkg::YAW_W-1:0] yaw,
                                            output bit produces,
                                            output yaw_beat_type beat);
      longint diff;
      longint x;
      longint alpha;
      longint mag;
      bit     neg;
      beat = '0;
      produces = 1'b0;
      if (!seen_first) begin
         seen_first = 1'b1;
         held_yaw = yaw;
         return;
      end
      diff = longint'($signed(yaw)) - longint'($signed(held_yaw));
      held_yaw = yaw;
      if (diff > longint'(yrlp_pkg::HALF_TURN)) diff -= longint'(yrlp_pkg::FULL_TURN);
      if (diff < -longint'(yrlp_pkg::HALF_TURN)) diff += longint'(yrlp_pkg::FULL_TURN);
      x = clamp_state(diff * (64'sd1 <<< FRAC_BITS));
      if (!stages_loaded) begin
         stage_a = x;
         stage_b = x;
         stages_loaded = 1'b1;
      end
      alpha = (gain_shadow > yrlp_pkg::GAIN_ONE) ? longint'(yrlp_pkg::GAIN_ONE)
                                                 : longint'(gain_shadow);
      stage_a = lowpass_step(stage_a, x, alpha);
      stage_b = lowpass_step(stage_b, stage_a, alpha);
      neg = stage_b < 0;
      mag = (neg ? -stage_b : stage_b) >>> FRAC_BITS;
      if (mag > MAG_MAX) mag = MAG_MAX;
      if (mag == 0) neg = 1'b0;
      beat.neg      = neg;
      beat.mag_high = mag[15:8];
      beat.mag_low  = mag[7:0];
      produces      = 1'b1;
   endfunction

   // one req beat; called and returns at a falling edge, tvalid left high
   task automatic send_sample(input logic [yrlp_pkg::YAW_W-1:0] yaw,
                              input row_check_type check,
                              input logic typed_neg,
                              input logic [yrlp_pkg::MAG_W-1:0] typed_mag);
      bit           produces;
      yaw_beat_type beat;
      int           gap;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= yaw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_yaw_rate(yaw, produces, beat);
      if (check == CHECK_TYPED) begin
         beat.neg      = typed_neg;
         beat.mag_high = typed_mag[15:8];
         beat.mag_low  = typed_mag[7:0];
         produces      = 1'b1;
      end else if (check == CHECK_NONE) begin
         produces = 1'b0;
      end
      if (produces) expected_beats.push_back(beat);
      @(negedge clock);
   endtask

   // stop sending and wait until the block has gone quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_filter_gain(input logic [yrlp_pkg::GAIN_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gain_shadow  = value;
   endtask

   // result side backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected rsp beat tuser=%0d tdata=%h", $time, rsp_tuser,
                     rsp_tdata);
            error_count++;
         end else begin
            if (rsp_tuser !== expected_beats[0].neg) begin
               $display("%0t: negative_flag expected %0d actual %0d", $time,
                        expected_beats[0].neg, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[7:0] !== expected_beats[0].mag_high) begin
               $display("%0t: magnitude_high expected %h actual %h", $time,
                        expected_beats[0].mag_high, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[15:8] !== expected_beats[0].mag_low) begin
               $display("%0t: magnitude_low expected %h actual %h", $time,
                        expected_beats[0].mag_low, rsp_tdata[15:8]);
               error_count++;
            end
            void'(expected_beats.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) break;
      end
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // stimulus
   initial begin
      int                          phase;
      int                          i;
      int                          walk;
      logic [yrlp_pkg::GAIN_W-1:0] gain_pick;
      logic [yrlp_pkg::YAW_W-1:0]  yaw_pick;
      walk = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].write_gain) set_filter_gain(directed_rows[i].gain);
         send_sample(directed_rows[i].yaw, directed_rows[i].check,
                     directed_rows[i].neg, directed_rows[i].mag);
      end
      walk = int'($signed(directed_rows[DIRECTED_ROWS-1].yaw));

      // random phases, one gain each; the last one runs without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       gain_pick = '0;
            1:       gain_pick = yrlp_pkg::GAIN_ONE;
            2:       gain_pick = '1;
            3:       gain_pick = yrlp_pkg::GAIN_W'($urandom_range(0, 65535));
            4:       gain_pick = yrlp_pkg::GAIN_RESET;
            default: gain_pick = yrlp_pkg::GAIN_W'($urandom_range(1000, 32768));
         endcase
         if (phase == RANDOM_PHASES - 1) begin
            send_gaps    = 1'b0;
            stall_enable = 1'b0;
         end
         set_filter_gain(gain_pick);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 9))
               // any 16-bit pattern
               0: yaw_pick = yrlp_pkg::YAW_W'($urandom_range(0, 65535));
               // step close to a half turn, either way
               1: begin
                  if ($urandom_range(0, 1))
                     yaw_pick = yrlp_pkg::YAW_W'(walk + $urandom_range(17990, 18010));
                  else
                     yaw_pick = yrlp_pkg::YAW_W'(walk - $urandom_range(17990, 18010));
               end
               // slow turning, kept inside one turn
               default: begin
                  walk = walk + $urandom_range(0, 600) - 300;
                  if (walk > 18000) walk -= 36000;
                  if (walk < -18000) walk += 36000;
                  yaw_pick = yrlp_pkg::YAW_W'(walk);
               end
            endcase
            walk = int'($signed(yaw_pick));
            if (send_gaps && $urandom_range(0, 39) == 0) drain_results();
            send_sample(yaw_pick, CHECK_MODEL, 1'b0, '0);
         end
      end

      // wind down
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
